// ===== src/msfbe_pkg.sv =====
// msfbe_pkg: shared constants, status codes and control structs for the
// end-taken maximum sum block; no dependencies
package msfbe_pkg;

  // default parameter values
  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 16;

  // fixed port widths
  localparam int IN_VAL_W  = 16;
  localparam int KEEP_W    = 11;
  localparam int SUM_OUT_W = 26;
  localparam int STATUS_W  = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_KEEP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

  // sequencer to scan datapath
  typedef struct packed {
    logic clear;   // start of a new scan, zero the best sum
    logic issue;   // a split is read from the store this cycle
    logic a_zero;  // front prefix index is zero
    logic b_zero;  // back prefix index is zero
  } scan_ctl_t;

  // scan datapath back to sequencer
  typedef struct packed {
    logic pipe_busy;
  } scan_sts_t;

endpackage

// ===== src/msfbe_store.sv =====
// msfbe_store: prefix sum memory, one write port, two read ports with
// registered read data; uses msfbe_pkg
module msfbe_store import msfbe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int SUM_W = 27
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SUM_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [SUM_W-1:0]         rd_a_data,
  output logic [SUM_W-1:0]         rd_b_data
);

  logic [SUM_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== src/msfbe_scan.sv =====
// msfbe_scan: split candidate pipeline, front prefix plus total minus back
// prefix, and running maximum; uses msfbe_pkg
module msfbe_scan import msfbe_pkg::*; #(
  parameter int SUM_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_ctl_t        ctl,
  input  logic [SUM_W-1:0] rd_a_data,
  input  logic [SUM_W-1:0] rd_b_data,
  input  logic [SUM_W-1:0] total,
  output logic [SUM_W-1:0] best,
  output scan_sts_t        sts
);

  logic             v1_r, az_r, bz_r;
  logic             v2_r;
  logic [SUM_W-1:0] cand_r, cand_nxt;
  logic [SUM_W-1:0] best_r;
  logic [SUM_W-1:0] pa, pb;

  // flags aligned with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
    end
    az_r <= ctl.a_zero;
    bz_r <= ctl.b_zero;
  end

  // candidate sum, entry zero of the prefix table reads as zero
  assign pa       = az_r ? '0 : rd_a_data;
  assign pb       = bz_r ? '0 : rd_b_data;
  assign cand_nxt = pa + total - pb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cand_r <= cand_nxt;
  end

  // running maximum
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_r <= '0;
    end else if (v2_r && (cand_r > best_r)) begin
      best_r <= cand_r;
    end
  end

  assign best          = best_r;
  assign sts.pipe_busy = v1_r | v2_r;

endmodule

// ===== src/max_sum_from_both_ends.sv =====
// max_sum_from_both_ends: top level, sequence intake, status check and
// split scan sequencer; uses msfbe_pkg, msfbe_store, msfbe_scan
// after a word without the last flag busy stays low; after the last word the
// block runs a check state, a scan state over keep_count+1 splits (one split
// per cycle over the two store read ports) and a drain state, then out_strobe
// status errors answer right after the check state; the receiver cannot stall
// reset: synchronous active low, keep_count returns to 1, sequence state clears
module max_sum_from_both_ends import msfbe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_VAL_W-1:0]  in_sample_value,
  input  logic                 in_is_last,
  output logic                 out_strobe,
  output logic [SUM_OUT_W-1:0] out_best_sum,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [KEEP_W-1:0]    cfg_wdata
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int CMP_W  = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam int BW     = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int VB_USE = (VALUE_BITS < IN_VAL_W) ? VALUE_BITS : IN_VAL_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [KEEP_W-1:0]    keep_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     window_r, window_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [SUM_OUT_W-1:0] sum_r, sum_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic                 accept, full;
  logic [SUM_W-1:0]     val_ext, wr_data;
  logic [CNT_W-1:0]     b_pos, idx_m1, b_m1;
  logic [CMP_W-1:0]     keep_ext, count_ext;
  logic [CNT_W-1:0]     keep_cnt;
  logic [SUM_W-1:0]     rd_a_data, rd_b_data, best;
  logic [BW-1:0]        best_ext;
  logic [SUM_OUT_W-1:0] best_sat;
  scan_ctl_t            ctl;
  scan_sts_t            sts;

  // intake
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign val_ext = SUM_W'(in_sample_value[VB_USE-1:0]);
  assign wr_data = total_r + val_ext;

  // keep count against sequence length
  assign keep_ext  = CMP_W'(keep_r);
  assign count_ext = CMP_W'(count_r);
  assign keep_cnt  = keep_ext[CNT_W-1:0];

  // split addresses: front prefix idx, back prefix idx + window
  assign b_pos  = idx_r + window_r;
  assign idx_m1 = idx_r - CNT_W'(1);
  assign b_m1   = b_pos - CNT_W'(1);

  assign ctl.clear  = (state_r == S_CHECK);
  assign ctl.issue  = (state_r == S_SCAN);
  assign ctl.a_zero = (idx_r == '0);
  assign ctl.b_zero = (b_pos == '0);

  // saturate the best sum to the output width
  assign best_ext = BW'(best);
  assign best_sat = (best_ext > BW'({SUM_OUT_W{1'b1}})) ? {SUM_OUT_W{1'b1}}
                                                        : best_ext[SUM_OUT_W-1:0];

  msfbe_store #(
    .DEPTH (DEPTH),
    .SUM_W (SUM_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (accept && !full),
    .wr_addr   (count_r[ADDR_W-1:0]),
    .wr_data   (wr_data),
    .rd_a_addr (idx_m1[ADDR_W-1:0]),
    .rd_b_addr (b_m1[ADDR_W-1:0]),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  msfbe_scan #(
    .SUM_W (SUM_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .total     (total_r),
    .best      (best),
    .sts       (sts)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    ovf_nxt    = ovf_r;
    window_nxt = window_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            total_nxt = wr_data;
          end
          if (in_is_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        window_nxt = count_r - keep_cnt;
        idx_nxt    = '0;
        if (ovf_r || (keep_ext > count_ext)) begin
          strobe_nxt = 1'b1;
          sum_nxt    = '0;
          status_nxt = ovf_r ? ST_OVF : ST_KEEP;
          count_nxt  = '0;
          total_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r == keep_cnt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          strobe_nxt = 1'b1;
          sum_nxt    = best_sat;
          status_nxt = ST_OK;
          count_nxt  = '0;
          total_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      total_r  <= '0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
      keep_r   <= KEEP_W'(1);
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    idx_r    <= idx_nxt;
    sum_r    <= sum_nxt;
    status_r <= status_nxt;
  end

  assign out_strobe   = strobe_r;
  assign out_best_sum = sum_r;
  assign out_status   = status_r;

`ifndef ASSERT_OFF
  // the fill count never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("item count beyond store depth");

  // a last word always starts the result sequence
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_is_last) |=> busy)
    else $error("last word did not start the scan");

  // a result follows a busy period and leaves the block idle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result outside a busy period");

  // error results carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_OK)) |-> (out_best_sum == '0))
    else $error("error result with nonzero sum");

  // the scan index stays within the keep count
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= keep_cnt))
    else $error("scan index past keep count");
`endif

endmodule

// ===== tb/msfbe_checker.sv =====
`timescale 1ns / 100ps
// msfbe_checker: watches the word, sum and keep count ports of
// max_sum_from_both_ends, predicts every sum word and compares it field by field
// depends on msfbe_pkg for port widths and status codes
module msfbe_checker import msfbe_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [IN_VAL_W-1:0]  in_sample_value,
  input  logic                 in_is_last,
  input  logic                 out_strobe,
  input  logic [SUM_OUT_W-1:0] out_best_sum,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [KEEP_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   sums_pending,
  output int                   sums_checked
);

  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_OUT_W) - 64'd1;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] best_sum;
    logic [STATUS_W-1:0]  status;
  } sum_word_t;

  // predicted sequence state
  logic [63:0]       prefix_sums [0:DEPTH];
  int unsigned       word_count;
  logic [63:0]       seq_total;
  logic              store_overflow;
  logic [KEEP_W-1:0] keep_count;
  sum_word_t         expected_sums [$];

  int miss_count = 0;
  int pass_count = 0;

  assign fail_count   = miss_count;
  assign sums_checked = pass_count;
  assign sums_pending = expected_sums.size();

  function automatic void clear_sequence();
    word_count     = 0;
    seq_total      = '0;
    store_overflow = 1'b0;
    prefix_sums[0] = '0;
  endfunction

  // total minus the lightest window of n - k words, over every split
  function automatic logic [63:0] best_end_sum(int unsigned n, int unsigned k);
    logic [63:0] best;
    logic [63:0] cand;
    int unsigned window_len;
    best       = '0;
    window_len = n - k;
    for (int unsigned i = 0; i <= k; i++) begin
      cand = prefix_sums[i] + seq_total - prefix_sums[i + window_len];
      if (cand > best) best = cand;
    end
    return best;
  endfunction

  always @(posedge clk) begin : watch
    sum_word_t   got;
    sum_word_t   want;
    logic [63:0] best;
    if (!rst_n) begin
      keep_count = KEEP_W'(1);
      clear_sequence();
      expected_sums.delete();
    end else begin
      // sum word leaving the block
      if (out_strobe) begin
        got.best_sum = out_best_sum;
        got.status   = out_status;
        if (expected_sums.size() == 0) begin
          if (miss_count < 10)
            $display("unexpected sum word at %0t: best_sum %0d status %0d",
                     $time, got.best_sum, got.status);
          miss_count++;
        end else begin
          want = expected_sums.pop_front();
          if (got.best_sum !== want.best_sum || got.status !== want.status) begin
            if (miss_count < 10)
              $display("mismatch at %0t: best_sum %0d status %0d, expected %0d status %0d",
                       $time, got.best_sum, got.status, want.best_sum, want.status);
            miss_count++;
          end else begin
            pass_count++;
          end
        end
      end

      // keep count register
      if (cfg_we) keep_count = cfg_wdata;

      // accepted word extends the prefix sums, last word closes the sequence
      if (start && !busy) begin
        if (word_count >= DEPTH) begin
          store_overflow = 1'b1;
        end else begin
          seq_total = seq_total + (64'(in_sample_value) & VALUE_MASK);
          word_count++;
          prefix_sums[word_count] = seq_total;
        end
        if (in_is_last) begin
          want.best_sum = '0;
          want.status   = ST_OK;
          if (store_overflow) begin
            want.status = ST_OVF;
          end else if (keep_count > word_count) begin
            want.status = ST_KEEP;
          end else begin
            best = best_end_sum(word_count, keep_count);
            if (best > SUM_LIMIT) best = SUM_LIMIT;
            want.best_sum = best[SUM_OUT_W-1:0];
          end
          expected_sums.push_back(want);
          clear_sequence();
        end
      end
    end
  end

endmodule

// ===== tb/tb_max_sum_from_both_ends.sv =====
`timescale 1ns / 100ps
// tb_max_sum_from_both_ends: drives value sequences and keep count settings
// into max_sum_from_both_ends, checking through msfbe_checker; uses msfbe_pkg
module tb_max_sum_from_both_ends;
  import msfbe_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [IN_VAL_W-1:0]  in_sample_value;
  logic                 in_is_last;
  logic                 out_strobe;
  logic [SUM_OUT_W-1:0] out_best_sum;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we;
  logic [KEEP_W-1:0]    cfg_wdata;

  int fail_count;
  int sums_pending;
  int sums_checked;

  int words_sent  = 0;
  int seqs_sent   = 0;
  int keep_writes = 0;
  int cycles      = 0;
  bit word_held   = 1'b0;

  max_sum_from_both_ends #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .in_is_last      (in_is_last),
    .out_strobe      (out_strobe),
    .out_best_sum    (out_best_sum),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  msfbe_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .in_is_last      (in_is_last),
    .out_strobe      (out_strobe),
    .out_best_sum    (out_best_sum),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .sums_pending    (sums_pending),
    .sums_checked    (sums_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // value mix: edges, small numbers, full random
  function automatic logic [IN_VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return IN_VAL_W'($urandom_range(0, 15));
      default: return IN_VAL_W'($urandom);
    endcase
  endfunction

  // idle gap after a word: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [KEEP_W-1:0] pick_keep();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 18) return KEEP_W'(1);
    if (r < 45) return KEEP_W'($urandom_range(2, 8));
    if (r < 75) return KEEP_W'($urandom_range(9, 40));
    if (r < 94) return KEEP_W'($urandom_range(41, 120));
    return KEEP_W'($urandom_range(DEPTH + 1, (1 << KEEP_W) - 1));
  endfunction

  // mostly at least keep count words long, some shorter, a few long ones
  function automatic int pick_length(int k);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (k > DEPTH) len = $urandom_range(1, 60);
    else if (r < 12 && k > 1) len = $urandom_range(1, k - 1);
    else if (r < 20) len = k + $urandom_range(0, 200);
    else len = k + $urandom_range(0, 30);
    if (len < 1) len = 1;
    if (len > DEPTH) len = DEPTH;
    return len;
  endfunction

  // one word, entered and left at a falling edge
  task automatic send_word(input logic [IN_VAL_W-1:0] value, input logic last,
                           input int gap);
    start           <= 1'b1;
    in_sample_value <= value;
    in_is_last      <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    @(negedge clk);
    word_held = 1'b1;
    if (gap > 0) begin
      start           <= 1'b0;
      in_sample_value <= IN_VAL_W'($urandom);
      in_is_last      <= 1'($urandom);
      word_held = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_sequence(input int len, input bit steady);
    for (int i = 1; i <= len; i++)
      send_word(pick_value(), i == len, steady ? 0 : pick_gap());
    seqs_sent++;
  endtask

  // hold off until every sum word is back and the block is idle
  task automatic wait_drained();
    if (word_held) begin
      start <= 1'b0;
      word_held = 1'b0;
    end
    @(negedge clk);
    while (sums_pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] keep);
    cfg_we    <= 1'b1;
    cfg_wdata <= keep;
    @(negedge clk);
    cfg_we    <= 1'b0;
    keep_writes++;
  endtask

  initial begin : stimulus
    int          random_start;
    int          phase_seqs;
    int          len;
    logic [KEEP_W-1:0] keep;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_sample_value = '0;
    in_is_last      = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset keep count of one, single word and end picks
    send_word('0, 1'b1, 0);
    send_word('1, 1'b0, 0);
    send_word(IN_VAL_W'(1), 1'b0, 1);
    send_word(IN_VAL_W'(16'hFFFE), 1'b1, 0);
    seqs_sent += 2;

    // keep count zero
    wait_drained();
    write_keep('0);
    send_word(IN_VAL_W'(16'h1234), 1'b0, 0);
    send_word('1, 1'b1, 0);

    // keep count of three: too long for two words, whole total, mixed ends
    wait_drained();
    write_keep(KEEP_W'(3));
    send_word(IN_VAL_W'(7), 1'b0, 0);
    send_word(IN_VAL_W'(9), 1'b1, 0);
    send_word(IN_VAL_W'(4), 1'b0, 2);
    send_word(IN_VAL_W'(9), 1'b0, 0);
    send_word(IN_VAL_W'(1), 1'b1, 0);
    send_word(IN_VAL_W'(9), 1'b0, 0);
    send_word(IN_VAL_W'(1), 1'b0, 0);
    send_word(IN_VAL_W'(1), 1'b0, 0);
    send_word(IN_VAL_W'(1), 1'b0, 0);
    send_word(IN_VAL_W'(8), 1'b1, 0);
    seqs_sent += 4;

    // keep count of two, front pair wins
    wait_drained();
    write_keep(KEEP_W'(2));
    send_word(IN_VAL_W'(2), 1'b0, 0);
    send_word(IN_VAL_W'(100), 1'b0, 0);
    send_word(IN_VAL_W'(3), 1'b0, 0);
    send_word(IN_VAL_W'(4), 1'b0, 0);
    send_word(IN_VAL_W'(90), 1'b1, 0);

    // largest keep count against a single word
    wait_drained();
    write_keep('1);
    send_word('1, 1'b1, 0);
    seqs_sent += 2;

    // store overflow on the last word, ahead of an oversized keep count
    wait_drained();
    write_keep('1);
    send_sequence(DEPTH + 1, 1'b0);

    // random phases of small sequences under changing keep counts
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      wait_drained();
      keep = pick_keep();
      write_keep(keep);
      phase_seqs = (keep > DEPTH) ? 2 : $urandom_range(2, 6);
      for (int s = 0; s < phase_seqs && words_sent - random_start < RANDOM_WORDS; s++) begin
        len = pick_length(int'(keep));
        send_sequence(len, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    // final drain
    wait_drained();
    repeat (40) @(negedge clk);

    $display("sent %0d words in %0d sequences over %0d keep count writes",
             words_sent, seqs_sent, keep_writes);
    $display("checked %0d sum words, including the store overflow case",
             sums_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
